// ===== sv/ppru_pkg.sv =====
// Shared types and constants for the packed pixel row unpacker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ppru_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_INDEX_OFFSET = 2'd2;

  // Pixel mode codes (any other code behaves as 8 bits per pixel)
  localparam logic [1:0] MODE_8BPP = 2'd0;
  localparam logic [1:0] MODE_4BPP = 2'd1;
  localparam logic [1:0] MODE_1BPP = 2'd2;

  // Fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned WIDTH_W = 13;
  localparam int unsigned CFG_W   = 13;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // How one data byte is unpacked
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,  // one 8-bit pixel
    KIND_NIB2 = 2'd1,  // two 4-bit pixels, high nibble first
    KIND_NIB1 = 2'd2,  // high nibble only, low nibble dropped
    KIND_BITS = 2'd3   // eight 1-bit pixels, msb first
  } kind_e;

  // One classified data byte
  typedef struct packed {
    logic [BYTE_W-1:0] row_byte;
    kind_e             kind;
    logic              last_data;
  } entry_t;

endpackage

// ===== sv/ppru_front.sv =====
// Front end of the unpacker: accepts row bytes, tracks the position within the
// padded row and classifies data bytes. Depends on ppru_pkg.
`timescale 1ns / 1ps

module ppru_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ppru_pkg::MODE_W-1:0]         pixel_mode_i,
  input  logic [ppru_pkg::WIDTH_W-1:0]        image_width_i,
  input  logic                                pos_clear_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ppru_pkg::BYTE_W-1:0]         row_byte_i,
  output logic                                push_o,
  output ppru_pkg::entry_t                    entry_o,
  input  logic                                q_ready_i
);

  localparam int unsigned EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned BITS_W = EW_W + 3;
  localparam int unsigned POS_W  = $clog2(MAX_WIDTH + 4);

  logic [EW_W-1:0]   eff_w;
  logic [BITS_W-1:0] row_bits;
  logic [BITS_W:0]   bits_rnd;
  logic [POS_W-1:0]  padlen;
  logic [POS_W-1:0]  nbytes;
  logic [EW_W:0]     w_ext;
  ppru_pkg::kind_e   kind_full;
  logic              is_4bpp;
  logic [POS_W-1:0]  pos_q, pos_d, pos_cur;
  logic [POS_W:0]    pos_inc;
  logic              has_data, last_data, accept;

  // Clamp width into 1..MAX_WIDTH
  always_comb begin
    if (image_width_i == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(image_width_i) > 32'(MAX_WIDTH)) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(image_width_i);
    end
  end

  assign w_ext = {1'b0, eff_w};

  // Row bits, data bytes and byte class per mode
  always_comb begin
    is_4bpp = 1'b0;
    unique case (pixel_mode_i)
      ppru_pkg::MODE_4BPP: begin
        row_bits  = {1'b0, eff_w, 2'b00};
        nbytes    = POS_W'((w_ext + (EW_W + 1)'(1)) >> 1);
        kind_full = ppru_pkg::KIND_NIB2;
        is_4bpp   = 1'b1;
      end
      ppru_pkg::MODE_1BPP: begin
        row_bits  = {3'b000, eff_w};
        nbytes    = POS_W'((w_ext + (EW_W + 1)'(7)) >> 3);
        kind_full = ppru_pkg::KIND_BITS;
      end
      default: begin
        row_bits  = {eff_w, 3'b000};
        nbytes    = POS_W'(eff_w);
        kind_full = ppru_pkg::KIND_BYTE;
      end
    endcase
  end

  // Padded row length in bytes: whole 32-bit words
  assign bits_rnd = {1'b0, row_bits} + (BITS_W + 1)'(31);
  assign padlen   = POS_W'({bits_rnd[BITS_W:5], 2'b00});

  // Classify the byte at the current position
  assign pos_cur   = (pos_q >= padlen) ? '0 : pos_q;
  assign pos_inc   = {1'b0, pos_cur} + (POS_W + 1)'(1);
  assign last_data = (pos_inc == {1'b0, nbytes});
  assign has_data  = (pos_cur < nbytes);

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && has_data;

  always_comb begin
    entry_o.row_byte  = row_byte_i;
    entry_o.last_data = last_data;
    if (is_4bpp && last_data && eff_w[0]) begin
      entry_o.kind = ppru_pkg::KIND_NIB1;
    end else begin
      entry_o.kind = kind_full;
    end
  end

  // Advance the row position, wrap after the padding
  always_comb begin
    pos_d = pos_q;
    if (pos_clear_i) begin
      pos_d = '0;
    end else if (accept) begin
      pos_d = (pos_inc >= {1'b0, padlen}) ? '0 : pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== sv/ppru_queue.sv =====
// Short queue of classified bytes between front and back end.
// Depends on ppru_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ppru_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ppru_pkg::entry_t push_entry_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output ppru_pkg::entry_t head_o
);

  localparam int unsigned Depth = ppru_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CNT_W = $clog2(Depth + 1);

  ppru_pkg::entry_t  mem_q [Depth];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign ready_o      = (count_q != CNT_W'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== sv/ppru_back.sv =====
// Back end of the unpacker: splits queued bytes into pixels, one per cycle unless stalled,
// adds the offset and holds each result in an output register. Uses ppru_pkg.
`timescale 1ns / 1ps

module ppru_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ppru_pkg::BYTE_W-1:0] index_offset_i,
  input  logic                        head_valid_i,
  input  ppru_pkg::entry_t            head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ppru_pkg::BYTE_W-1:0] pixel_index_o,
  output logic                        last_of_byte_o,
  output logic                        row_end_o
);

  logic [2:0]                  sub_q, sub_d;
  logic                        out_valid_q, out_valid_d;
  logic [ppru_pkg::BYTE_W-1:0] pix_q, pix_d, raw;
  logic                        lob_q, lob_d, re_q, re_d;
  logic                        load, fin;

  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  // Select the pixel at the current sub-position
  always_comb begin
    unique case (head_i.kind)
      ppru_pkg::KIND_BYTE: begin
        raw = head_i.row_byte;
        fin = 1'b1;
      end
      ppru_pkg::KIND_NIB2: begin
        raw = sub_q[0] ? {4'h0, head_i.row_byte[3:0]} : {4'h0, head_i.row_byte[7:4]};
        fin = sub_q[0];
      end
      ppru_pkg::KIND_NIB1: begin
        raw = {4'h0, head_i.row_byte[7:4]};
        fin = 1'b1;
      end
      ppru_pkg::KIND_BITS: begin
        raw = {7'd0, head_i.row_byte[~sub_q]};
        fin = (sub_q == 3'd7);
      end
      default: begin
        raw = head_i.row_byte;
        fin = 1'b1;
      end
    endcase
  end

  assign pop_o = load && fin;

  // Load the output register, hold while stalled
  always_comb begin
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    pix_d       = pix_q;
    lob_d       = lob_q;
    re_d        = re_q;
    if (load) begin
      out_valid_d = 1'b1;
      pix_d       = raw + index_offset_i;
      lob_d       = fin;
      re_d        = fin && head_i.last_data;
      sub_d       = fin ? 3'd0 : sub_q + 3'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    lob_q <= lob_d;
    re_q  <= re_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_index_o  = pix_q;
  assign last_of_byte_o = lob_q;
  assign row_end_o      = re_q;

endmodule

// ===== sv/packed_pixel_row_unpacker_core.sv =====
// Packed pixel row unpacker: takes the bytes of indexed bitmap rows (each row
// padded to a multiple of four bytes) and emits one palette index per pixel at
// 8, 4 or 1 bits per pixel, with a wrapping offset added. The front end takes
// one byte per cycle while the queue has room and drops padding bytes; a
// two-entry queue feeds the back end, which issues one pixel per cycle through
// a registered output while the output is not stalled. A data byte yields one
// pixel at 8 bpp, two at 4 bpp (one for the last byte of an odd-width row)
// and eight at 1 bpp. Writing pixel_mode or image_width restarts the row; write
// configuration only while no transaction is in flight.
// Depends on ppru_pkg, ppru_front, ppru_queue and ppru_back.
`timescale 1ns / 1ps

module packed_pixel_row_unpacker_core #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ppru_pkg::CFG_W-1:0]  cfg_data_i,
  // Row bytes in
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ppru_pkg::BYTE_W-1:0] row_byte_i,
  // Pixels out
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ppru_pkg::BYTE_W-1:0] pixel_index_o,
  output logic                        last_of_byte_o,
  output logic                        row_end_o
);

  logic [ppru_pkg::MODE_W-1:0]  pixel_mode_q;
  logic [ppru_pkg::WIDTH_W-1:0] image_width_q;
  logic [ppru_pkg::BYTE_W-1:0]  index_offset_q;
  logic                         cfg_we, pos_clear;
  logic                         push, q_ready, pop, head_valid;
  ppru_pkg::entry_t             push_entry, head;

  // Register file: always ready, unknown indexes ignored
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign pos_clear   = cfg_we && ((cfg_index_i == ppru_pkg::REG_PIXEL_MODE) ||
                                  (cfg_index_i == ppru_pkg::REG_IMAGE_WIDTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_mode_q   <= ppru_pkg::MODE_8BPP;
      image_width_q  <= ppru_pkg::WIDTH_W'(1);
      index_offset_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        ppru_pkg::REG_PIXEL_MODE:   pixel_mode_q   <= cfg_data_i[ppru_pkg::MODE_W-1:0];
        ppru_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[ppru_pkg::WIDTH_W-1:0];
        ppru_pkg::REG_INDEX_OFFSET: index_offset_q <= cfg_data_i[ppru_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  ppru_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_mode_i (pixel_mode_q),
    .image_width_i(image_width_q),
    .pos_clear_i  (pos_clear),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .row_byte_i   (row_byte_i),
    .push_o       (push),
    .entry_o      (push_entry),
    .q_ready_i    (q_ready)
  );

  ppru_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  ppru_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .index_offset_i(index_offset_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_o (pixel_index_o),
    .last_of_byte_o(last_of_byte_o),
    .row_end_o     (row_end_o)
  );

endmodule

// ===== verif/ppru_pixel_checker.sv =====
// Pixel checker for the packed pixel row unpacker: watches the config, byte and pixel channels.
// Predicts the pixels of every accepted byte and compares them in order.
// Depends on ppru_pkg.
`timescale 1ns / 1ps

module ppru_pixel_checker #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [ppru_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [ppru_pkg::BYTE_W-1:0]  row_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [ppru_pkg::BYTE_W-1:0]  pixel_index_i,
  input  logic                         last_of_byte_i,
  input  logic                         row_end_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic [ppru_pkg::BYTE_W-1:0] pixel_index;
    logic                        last_of_byte;
    logic                        row_end;
  } pixel_t;

  pixel_t                       expected_pixels[$];
  logic [ppru_pkg::MODE_W-1:0]  mode_q;
  logic [ppru_pkg::WIDTH_W-1:0] width_q;
  logic [ppru_pkg::BYTE_W-1:0]  offset_q;
  int unsigned                  row_pos_q;
  int                           mismatches = 0;
  int                           pending = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Queue one pixel with the offset applied, wrapping at 8 bits
  function automatic void expect_pixel(input logic [ppru_pkg::BYTE_W-1:0] value,
                                       input logic lob, input logic re);
    pixel_t p;
    p.pixel_index  = value + offset_q;
    p.last_of_byte = lob;
    p.row_end      = re;
    expected_pixels.insert(expected_pixels.size(), p);
  endfunction

  // Unpack one row byte according to the current mode and width
  task automatic unpack_row_byte(input logic [ppru_pkg::BYTE_W-1:0] b);
    int unsigned bpp, w, nbytes, padlen, pos;
    logic        last_data;
    case (mode_q)
      ppru_pkg::MODE_4BPP: bpp = 4;
      ppru_pkg::MODE_1BPP: bpp = 1;
      default:             bpp = 8;
    endcase
    w = width_q;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    nbytes = (bpp == 4) ? (w + 1) / 2 : (bpp == 1) ? (w + 7) / 8 : w;
    padlen = ((bpp * w + 31) / 32) * 4;
    pos = row_pos_q;
    if (pos >= padlen) pos = 0;
    last_data = (pos + 1 == nbytes);
    // Padding bytes produce nothing
    if (pos < nbytes) begin
      if (bpp == 8) begin
        expect_pixel(b, 1'b1, last_data);
      end else if (bpp == 4) begin
        // Odd width: drop the low nibble of the last data byte
        if (last_data && (w % 2 == 1)) begin
          expect_pixel({4'h0, b[7:4]}, 1'b1, 1'b1);
        end else begin
          expect_pixel({4'h0, b[7:4]}, 1'b0, 1'b0);
          expect_pixel({4'h0, b[3:0]}, 1'b1, last_data);
        end
      end else begin
        for (int i = 0; i < 8; i++) begin
          expect_pixel({7'b0, b[7-i]}, i == 7, (i == 7) && last_data);
        end
      end
    end
    pos++;
    if (pos >= padlen) pos = 0;
    row_pos_q = pos;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    if (!rst_ni) begin
      mode_q    = ppru_pkg::MODE_8BPP;
      width_q   = 13'd1;
      offset_q  = '0;
      row_pos_q = 0;
      expected_pixels.delete();
      pending   = 0;
    end else begin
      // Compare each pixel transaction against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got = '{pixel_index_i, last_of_byte_i, row_end_i};
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %0d", got.pixel_index));
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel_index !== want.pixel_index)
            report_mismatch($sformatf("pixel_index got %0d want %0d",
                                      got.pixel_index, want.pixel_index));
          if (got.last_of_byte !== want.last_of_byte)
            report_mismatch($sformatf("last_of_byte got %0b want %0b",
                                      got.last_of_byte, want.last_of_byte));
          if (got.row_end !== want.row_end)
            report_mismatch($sformatf("row_end got %0b want %0b",
                                      got.row_end, want.row_end));
        end
      end
      // Mirror register writes; mode and width restart the row
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ppru_pkg::REG_PIXEL_MODE: begin
            mode_q    = cfg_data_i[ppru_pkg::MODE_W-1:0];
            row_pos_q = 0;
          end
          ppru_pkg::REG_IMAGE_WIDTH: begin
            width_q   = cfg_data_i[ppru_pkg::WIDTH_W-1:0];
            row_pos_q = 0;
          end
          ppru_pkg::REG_INDEX_OFFSET: offset_q = cfg_data_i[ppru_pkg::BYTE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) unpack_row_byte(row_byte_i);
      pending = expected_pixels.size();
    end
  end

endmodule

// ===== verif/packed_pixel_row_unpacker_core_tb.sv =====
// Testbench top for the packed pixel row unpacker: drives config writes and row bytes,
// applies random back-pressure and gives the verdict.
// Depends on ppru_pkg, packed_pixel_row_unpacker_core and ppru_pixel_checker.
`timescale 1ns / 1ps

module packed_pixel_row_unpacker_core_tb;

  localparam int unsigned MAX_WIDTH     = 4096;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_BYTES  = 450;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [1:0]                   cfg_index_i = '0;
  logic [ppru_pkg::CFG_W-1:0]   cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [ppru_pkg::BYTE_W-1:0]  row_byte_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [ppru_pkg::BYTE_W-1:0]  pixel_index_o;
  logic                         last_of_byte_o;
  logic                         row_end_o;

  int                           send_idle_pct = 21;
  int                           recv_idle_pct = 47;
  logic [ppru_pkg::MODE_W-1:0]  cur_mode = ppru_pkg::MODE_8BPP;
  logic [ppru_pkg::WIDTH_W-1:0] cur_width = 13'd1;
  int unsigned                  bytes_sent = 0;
  int                           mismatch_count;
  int                           pending_pixels;

  always #5 clk_i = ~clk_i;

  // Random back-pressure on the pixel channel
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  packed_pixel_row_unpacker_core #(.MAX_WIDTH(MAX_WIDTH)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .row_byte_i    (row_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_o (pixel_index_o),
    .last_of_byte_o(last_of_byte_o),
    .row_end_o     (row_end_o)
  );

  ppru_pixel_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .row_byte_i    (row_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_i (pixel_index_o),
    .last_of_byte_i(last_of_byte_o),
    .row_end_i     (row_end_o),
    .fail_count_o  (mismatch_count),
    .pending_o     (pending_pixels)
  );

  // Data bytes and padded length of a row under the current settings
  function automatic void row_shape(output int unsigned nbytes, output int unsigned padlen);
    int unsigned bpp, w;
    case (cur_mode)
      ppru_pkg::MODE_4BPP: bpp = 4;
      ppru_pkg::MODE_1BPP: bpp = 1;
      default:             bpp = 8;
    endcase
    w = cur_width;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    nbytes = (bpp == 4) ? (w + 1) / 2 : (bpp == 1) ? (w + 7) / 8 : w;
    padlen = ((bpp * w + 31) / 32) * 4;
  endfunction

  // Hold a register write until accepted; valid is lowered by the next byte
  task automatic write_reg(input logic [1:0] idx, input logic [ppru_pkg::CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ppru_pkg::REG_PIXEL_MODE:  cur_mode  = data[ppru_pkg::MODE_W-1:0];
      ppru_pkg::REG_IMAGE_WIDTH: cur_width = data[ppru_pkg::WIDTH_W-1:0];
      default: ;
    endcase
  endtask

  // Send one row byte transaction, with random gaps before it
  task automatic send_byte(input logic [ppru_pkg::BYTE_W-1:0] b);
    if (bytes_sent >= 320) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (bytes_sent >= 160) begin
      send_idle_pct = 47;
      recv_idle_pct = 21;
    end
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // Stop sending until every predicted pixel has come out, then let the pipe settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_pixels != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [ppru_pkg::CFG_W-1:0] cfg_word;
    int unsigned                nbytes, padlen, count, target;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: 8 bpp, width 1, so one data byte and three padding bytes
    send_byte(8'h00);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'hFF);
    wait_drained();

    // 4 bpp, odd width with wrapping offset: low nibble of the last byte dropped
    write_reg(ppru_pkg::REG_INDEX_OFFSET, 13'h00FF);
    write_reg(ppru_pkg::REG_PIXEL_MODE, {11'b0, ppru_pkg::MODE_4BPP});
    write_reg(ppru_pkg::REG_IMAGE_WIDTH, 13'd3);
    send_byte(8'hF0);
    send_byte(8'h1E);
    send_byte(8'h77);
    send_byte(8'h88);
    send_byte(8'hAB);
    wait_drained();

    // 1 bpp: every bit of a data byte emitted, also past the row width
    write_reg(ppru_pkg::REG_PIXEL_MODE, {11'b0, ppru_pkg::MODE_1BPP});
    write_reg(ppru_pkg::REG_IMAGE_WIDTH, 13'd9);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h5A);
    send_byte(8'hA5);
    wait_drained();

    // Unused mode acts as 8 bpp, width 0 acts as 1, unknown register ignored
    write_reg(ppru_pkg::REG_PIXEL_MODE, 13'h1FFF);
    write_reg(ppru_pkg::REG_IMAGE_WIDTH, 13'd0);
    write_reg(ppru_pkg::REG_INDEX_OFFSET, 13'h1F00);
    write_reg(REG_UNUSED, 13'h1FFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained();

    // Mid-row writes: offset keeps the position, width restarts the row
    write_reg(ppru_pkg::REG_PIXEL_MODE, {11'b0, ppru_pkg::MODE_8BPP});
    write_reg(ppru_pkg::REG_IMAGE_WIDTH, 13'd5);
    send_byte(8'h10);
    send_byte(8'h20);
    wait_drained();
    write_reg(ppru_pkg::REG_INDEX_OFFSET, 13'h0010);
    send_byte(8'h30);
    wait_drained();
    write_reg(ppru_pkg::REG_IMAGE_WIDTH, 13'd6);
    send_byte(8'h40);
    send_byte(8'hEF);

    // Random segments: new settings when idle, then whole rows of random bytes
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      wait_drained();
      if ($urandom_range(99) < 60) begin
        cfg_word = ppru_pkg::CFG_W'($urandom);
        cfg_word[ppru_pkg::MODE_W-1:0] = ppru_pkg::MODE_W'($urandom_range(3));
        write_reg(ppru_pkg::REG_PIXEL_MODE, cfg_word);
      end
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(4))
            0:       cfg_word = 13'd0;
            1:       cfg_word = 13'd4096;
            2:       cfg_word = 13'd4097;
            3:       cfg_word = 13'd8191;
            default: cfg_word = ppru_pkg::CFG_W'($urandom_range(41, 8191));
          endcase
        end else begin
          cfg_word = ppru_pkg::CFG_W'($urandom_range(1, 40));
        end
        write_reg(ppru_pkg::REG_IMAGE_WIDTH, cfg_word);
      end
      if ($urandom_range(99) < 50) begin
        cfg_word = ppru_pkg::CFG_W'($urandom);
        if ($urandom_range(5) == 0) cfg_word[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
        write_reg(ppru_pkg::REG_INDEX_OFFSET, cfg_word);
      end
      if ($urandom_range(9) == 0) begin
        cfg_word = ppru_pkg::CFG_W'($urandom);
        write_reg(REG_UNUSED, cfg_word);
      end
      // Short rows get whole rows plus sometimes a broken tail; long rows a few bytes
      row_shape(nbytes, padlen);
      if (padlen <= 64) begin
        count = padlen * $urandom_range(1, 3);
        if ($urandom_range(3) == 0) count += $urandom_range(1, padlen - 1);
      end else begin
        count = $urandom_range(1, 40);
      end
      // Stop at the byte budget
      if (count > target - bytes_sent) count = target - bytes_sent;
      repeat (count) send_byte(ppru_pkg::BYTE_W'($urandom));
    end

    wait_drained();
    if (mismatch_count == 0 && pending_pixels == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
